// ----- hw/rtl/value_contrast_curve_top_defines.svh -----
// ----------------------------------------------------------------------------
// value_contrast_curve_top_defines
// Assertion macros shared by the contrast curve RTL.
// ----------------------------------------------------------------------------
`ifndef VALUE_CONTRAST_CURVE_TOP_DEFINES_SVH
`define VALUE_CONTRAST_CURVE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define VCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define VCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define VCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/vcc_pkg.sv -----
// ----------------------------------------------------------------------------
// vcc_pkg
// Widths, register indexes, curve codes and fixed-point constants.
// ----------------------------------------------------------------------------
package vcc_pkg;

    localparam int DATA_W    = 32;
    localparam int SPAN_W    = 31;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SPAN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SQUARE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CUBE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SQRT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CBRT   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CCUBE  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CROOT  = 3'd6;

    // floor(2^32 * p) for the two exponents
    localparam logic [30:0] K_CBRT  = 31'd1431512599;
    localparam logic [30:0] K_CROOT = 31'd1417339207;
    localparam logic [12:0] NUM_CBRT  = 13'd3333;
    localparam logic [13:0] DEN_CBRT  = 14'd10000;
    localparam logic [12:0] NUM_CROOT = 13'd33;
    localparam logic [13:0] DEN_CROOT = 14'd100;

    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;

    // elaboration only: floor square root of a 64-bit value
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // elaboration only: Q0.30 factor 2^(-2^-i)
    function automatic logic [29:0] pow_factor(input int i);
        logic [63:0] h;
        h = 64'd1 << 29;
        for (int k = 0; k < i; k++) begin
            h = isqrt64(h << 30);
        end
        return h[29:0];
    endfunction

endpackage

// ----- hw/rtl/vcc_in_if.sv -----
// ----------------------------------------------------------------------------
// vcc_in_if
// Sample channel: one Q16.16 sample and its block-end marker per beat.
// ----------------------------------------------------------------------------
interface vcc_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [vcc_pkg::DATA_W-1:0] sample_value;
    logic                              last_in;

    modport source(output valid, output sample_value, output last_in, input ready);
    modport sink(input valid, input sample_value, input last_in, output ready);
endinterface

// ----- hw/rtl/vcc_out_if.sv -----
// ----------------------------------------------------------------------------
// vcc_out_if
// Result channel: mapped value, saturation flag and block-end marker.
// ----------------------------------------------------------------------------
interface vcc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [vcc_pkg::DATA_W-1:0] curve_value;
    logic                              saturated;
    logic                              last_out;

    modport source(output valid, output curve_value, output saturated, output last_out,
                   input ready);
    modport sink(input valid, input curve_value, input saturated, input last_out,
                 output ready);
endinterface

// ----- hw/rtl/vcc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// vcc_cfg_if
// Register write channel: index and data per beat.
// ----------------------------------------------------------------------------
interface vcc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [vcc_pkg::CFG_IDX_W-1:0]        index;
    logic [vcc_pkg::DATA_W-1:0]           data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/value_contrast_curve_top.sv -----
// ----------------------------------------------------------------------------
// value_contrast_curve_top
// Normalizes Q16.16 samples by a configured range and applies a transfer curve.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample carries one signed Q16.16 sample and a last flag per beat; o_curve
//   returns the mapped value, a saturation flag and the copied last flag.
//   i_cfg writes range_minimum (index 0), range_span (1) and curve_mode (2);
//   it is always ready and should only be used while no sample is in flight.
//   Throughput is one sample per cycle while the receiver does not stall. The
//   result beat passes 104 register stages: 49 stages of the radix-2
//   restoring divider, 24 squaring stages of the log2 step, 24 product stages
//   of the exp2 step and the entry, clamp, multiply, normalization, scaling and
//   final selection stages.
//   Reset clears all stage valid bits and loads the register defaults
//   (minimum 0, span 1.0, linear curve). When the receiver stalls, the whole
//   pipeline holds and i_sample.ready drops in the same cycle; nothing is lost.
// ----------------------------------------------------------------------------
`include "value_contrast_curve_top_defines.svh"

module value_contrast_curve_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vcc_in_if.sink      i_sample,
    vcc_out_if.source   o_curve,
    vcc_cfg_if.sink     i_cfg
);

    localparam int QW      = 49;             // quotient bits
    localparam int DIV_N   = QW;             // last divider stage
    localparam int ST_A    = DIV_N + 1;      // clamp and centre
    localparam int ST_B    = ST_A + 1;       // first products, log setup
    localparam int ST_C    = ST_B + 1;       // second products
    localparam int ST_D    = ST_C + 1;       // simple curve results
    localparam int SQ0     = ST_C;
    localparam int SQ_LAST = SQ0 + 16;
    localparam int LG0     = ST_C;
    localparam int LG_LAST = LG0 + 23;
    localparam int ST_NL   = LG_LAST + 1;
    localparam int ST_QE   = ST_NL + 1;
    localparam int ST_NT   = ST_QE + 1;
    localparam int PR0     = ST_NT + 1;
    localparam int PR_LAST = PR0 + 23;
    localparam int ST_FIN  = PR_LAST + 1;

    typedef struct packed {
        logic        last;
        logic [31:0] s;
        logic        neg;
        logic [30:0] rem;
        logic [48:0] nq;
        logic [16:0] c;
        logic        dneg;
        logic [15:0] dm;
        logic [49:0] sq;
        logic [64:0] cb;
        logic [47:0] dc;
        logic [31:0] sv;
        logic        sf;
        logic [16:0] sr;
        logic        xz;
        logic [4:0]  e;
        logic [30:0] m;
        logic [23:0] fb;
        logic [28:0] nl;
        logic [27:0] qe;
        logic [27:0] nt;
        logic [30:0] y;
        logic [31:0] ov;
        logic        of;
    } t_stage;

    logic [vcc_pkg::DATA_W-1:0] r_min;
    logic [vcc_pkg::SPAN_W-1:0] r_span;
    logic [vcc_pkg::MODE_W-1:0] r_mode;
    logic [vcc_pkg::SPAN_W-1:0] span_eff;

    logic [ST_FIN:0] r_vld;
    t_stage          r_st [0:ST_FIN];
    t_stage          n_st [0:ST_FIN];
    logic            pipe_en;
    logic            is_root;
    logic            is_unit;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= '0;
            r_span <= 31'd65536;
            r_mode <= vcc_pkg::MODE_LINEAR;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                vcc_pkg::CFG_RANGE_MIN:  r_min  <= i_cfg.data;
                vcc_pkg::CFG_RANGE_SPAN: r_span <= i_cfg.data[vcc_pkg::SPAN_W-1:0];
                vcc_pkg::CFG_CURVE_MODE: r_mode <= i_cfg.data[vcc_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // zero span acts as one LSB
    assign span_eff = (r_span == '0) ? 31'd1 : r_span;

    // global stall: hold every stage while the result beat waits
    assign pipe_en        = !r_vld[ST_FIN] || o_curve.ready;
    assign i_sample.ready = pipe_en;

    // entry: exact 33-bit offset, magnitude scaled by 2^16
    always_comb begin
        logic [32:0] diff;
        logic [32:0] absd;
        diff = {i_sample.sample_value[31], i_sample.sample_value} - {r_min[31], r_min};
        absd = diff[32] ? (~diff + 33'd1) : diff;
        n_st[0]      = '0;
        n_st[0].last = i_sample.last_in;
        n_st[0].s    = i_sample.sample_value;
        n_st[0].neg  = diff[32];
        n_st[0].nq   = {absd, 16'b0};
    end

    for (genvar j = 1; j <= ST_FIN; j++) begin : g_stage
        localparam int SB = (j >= SQ0 && j <= SQ_LAST) ? (SQ_LAST - j) : 0;
        localparam int PB = (j >= PR0 && j <= PR_LAST) ? (PR_LAST - j) : 0;
        localparam logic [29:0] HF = vcc_pkg::pow_factor(j - PR0 + 1);

        always_comb begin
            logic [31:0] dv;
            logic [31:0] tr;
            logic        ge;
            logic [48:0] mag;
            logic [16:0] x;
            logic [4:0]  ee;
            logic [16:0] trial;
            logic [33:0] tsq;
            logic [61:0] msq;
            logic [31:0] mm;
            logic [30:0] kc;
            logic [59:0] kp;
            logic [12:0] cnum;
            logic [13:0] cden;
            logic [41:0] rnum;
            logic [41:0] rden;
            logic [60:0] yp;
            logic [33:0] q2;
            logic [32:0] q3;
            logic [30:0] yk;
            logic [31:0] ysum;
            logic [16:0] pw;
            logic [19:0] p5;
            logic [16:0] q6;

            n_st[j] = r_st[j-1];
            mag     = r_st[j-1].nq;

            // one quotient bit per stage
            if (j <= DIV_N) begin
                dv = {1'b0, span_eff};
                tr = {r_st[j-1].rem, r_st[j-1].nq[48]};
                ge = (tr >= dv);
                n_st[j].rem = ge ? 31'(tr - dv) : tr[30:0];
                n_st[j].nq  = {r_st[j-1].nq[47:0], ge};
            end

            if (j == ST_A) begin
                if (r_st[j-1].neg) begin
                    n_st[j].c = '0;
                end else if (mag > 49'd65536) begin
                    n_st[j].c = 17'd65536;
                end else begin
                    n_st[j].c = mag[16:0];
                end
                n_st[j].dneg = (n_st[j].c < 17'd32768);
                n_st[j].dm   = n_st[j].dneg ? 16'(17'd32768 - n_st[j].c)
                                            : 16'(n_st[j].c - 17'd32768);
                n_st[j].sr   = '0;
            end

            if (j == ST_B) begin
                n_st[j].sq = {25'b0, mag[24:0]} * {25'b0, mag[24:0]};
                n_st[j].cb = {21'b0, 44'({22'b0, mag[21:0]} * {22'b0, mag[21:0]})};
                n_st[j].dc = {16'b0, r_st[j-1].dm} * {32'b0, r_st[j-1].dm};
                x  = (r_mode == vcc_pkg::MODE_CBRT) ? r_st[j-1].c : {1'b0, r_st[j-1].dm};
                ee = '0;
                for (int b = 0; b < 17; b++) begin
                    if (x[b]) ee = 5'(b);
                end
                n_st[j].xz = (x == '0);
                n_st[j].e  = ee;
                n_st[j].m  = {14'b0, x} << (5'd30 - ee);
                n_st[j].fb = '0;
            end

            if (j == ST_C) begin
                n_st[j].cb = {22'b0, r_st[j-1].cb[42:0]} * {43'b0, mag[21:0]};
                n_st[j].dc = {16'b0, r_st[j-1].dc[31:0]} * {32'b0, r_st[j-1].dm};
            end

            if (j == ST_D) begin
                q2 = r_st[j-1].sq[49:16];
                q3 = r_st[j-1].cb[64:32];
                n_st[j].sf = 1'b0;
                case (r_mode)
                    vcc_pkg::MODE_LINEAR: begin
                        if (!r_st[j-1].neg) begin
                            if (mag > 49'h7FFF_FFFF) begin
                                n_st[j].sv = vcc_pkg::INT_MAX;
                                n_st[j].sf = 1'b1;
                            end else begin
                                n_st[j].sv = mag[31:0];
                            end
                        end else if (mag > 49'h8000_0000) begin
                            n_st[j].sv = vcc_pkg::INT_MIN;
                            n_st[j].sf = 1'b1;
                        end else begin
                            n_st[j].sv = 32'd0 - mag[31:0];
                        end
                    end
                    vcc_pkg::MODE_SQUARE: begin
                        if (mag > 49'h100_0000 || q2 > 34'h7FFF_FFFF) begin
                            n_st[j].sv = vcc_pkg::INT_MAX;
                            n_st[j].sf = 1'b1;
                        end else begin
                            n_st[j].sv = q2[31:0];
                        end
                    end
                    vcc_pkg::MODE_CUBE: begin
                        if (mag > 49'h20_0000) begin
                            n_st[j].sv = r_st[j-1].neg ? vcc_pkg::INT_MIN : vcc_pkg::INT_MAX;
                            n_st[j].sf = 1'b1;
                        end else if (r_st[j-1].neg) begin
                            n_st[j].sv = 32'd0 - q3[31:0];
                        end else if (q3 > 33'h7FFF_FFFF) begin
                            n_st[j].sv = vcc_pkg::INT_MAX;
                            n_st[j].sf = 1'b1;
                        end else begin
                            n_st[j].sv = q3[31:0];
                        end
                    end
                    vcc_pkg::MODE_CCUBE: begin
                        n_st[j].sv = r_st[j-1].dneg
                                   ? 32'd32768 - {14'b0, r_st[j-1].dc[47:30]}
                                   : 32'd32768 + {14'b0, r_st[j-1].dc[47:30]};
                    end
                    default: begin
                        n_st[j].sv = r_st[j-1].s;
                    end
                endcase
            end

            // square root, one result bit per stage
            if (j >= SQ0 && j <= SQ_LAST) begin
                trial = r_st[j-1].sr | (17'd1 << SB);
                tsq   = {17'b0, trial} * {17'b0, trial};
                if (tsq <= {1'b0, r_st[j-1].c, 16'b0}) n_st[j].sr = trial;
            end

            // log2 mantissa: square, take one fraction bit
            if (j >= LG0 && j <= LG_LAST) begin
                msq = {31'b0, r_st[j-1].m} * {31'b0, r_st[j-1].m};
                mm  = msq[61:30];
                n_st[j].fb = {r_st[j-1].fb[22:0], mm[31]};
                n_st[j].m  = mm[31] ? mm[31:1] : mm[30:0];
            end

            if (j == ST_NL) begin
                n_st[j].nl = {5'(5'd16 - r_st[j-1].e), 24'b0} - {5'b0, r_st[j-1].fb};
            end

            // scale by the exponent: reciprocal estimate, then one correction
            if (j == ST_QE) begin
                kc = (r_mode == vcc_pkg::MODE_CBRT) ? vcc_pkg::K_CBRT : vcc_pkg::K_CROOT;
                kp = {31'b0, r_st[j-1].nl} * {29'b0, kc};
                n_st[j].qe = kp[59:32];
            end

            if (j == ST_NT) begin
                cnum = (r_mode == vcc_pkg::MODE_CBRT) ? vcc_pkg::NUM_CBRT
                                                      : vcc_pkg::NUM_CROOT;
                cden = (r_mode == vcc_pkg::MODE_CBRT) ? vcc_pkg::DEN_CBRT
                                                      : vcc_pkg::DEN_CROOT;
                rnum = {13'b0, r_st[j-1].nl} * {29'b0, cnum};
                rden = {14'b0, r_st[j-1].qe} * {28'b0, cden};
                n_st[j].nt = ((rnum - rden) >= {28'b0, cden}) ? r_st[j-1].qe + 28'd1
                                                               : r_st[j-1].qe;
                n_st[j].y  = 31'h4000_0000;
            end

            // exp2 of the fraction: one factor per stage
            if (j >= PR0 && j <= PR_LAST) begin
                if (r_st[j-1].nt[PB]) begin
                    yp = {30'b0, r_st[j-1].y} * {31'b0, HF};
                    n_st[j].y = yp[60:30];
                end
            end

            if (j == ST_FIN) begin
                yk   = r_st[j-1].y >> r_st[j-1].nt[27:24];
                ysum = {1'b0, yk} + 32'd8192;
                pw   = r_st[j-1].xz ? 17'd0 : ysum[30:14];
                p5   = ({3'b0, pw} << 2) + {3'b0, pw} + 20'd4;
                q6   = p5[19:3];
                n_st[j].of = 1'b0;
                case (r_mode)
                    vcc_pkg::MODE_SQRT: n_st[j].ov = {15'b0, r_st[j-1].sr};
                    vcc_pkg::MODE_CBRT: n_st[j].ov = {15'b0, pw};
                    vcc_pkg::MODE_CROOT: begin
                        n_st[j].ov = r_st[j-1].dneg ? 32'd32768 - {15'b0, q6}
                                                    : 32'd32768 + {15'b0, q6};
                    end
                    default: begin
                        n_st[j].ov = r_st[j-1].sv;
                        n_st[j].of = r_st[j-1].sf;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[ST_FIN-1:0], i_sample.valid};
        end
    end

    // payload: advance with the valid bits, no reset
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            for (int k = 0; k <= ST_FIN; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_curve.valid       = r_vld[ST_FIN];
    assign o_curve.curve_value = r_st[ST_FIN].ov;
    assign o_curve.saturated   = r_st[ST_FIN].of;
    assign o_curve.last_out    = r_st[ST_FIN].last;

    // root curves bounded by one, and those plus the centred cube curve
    assign is_unit = (r_mode == vcc_pkg::MODE_SQRT) || (r_mode == vcc_pkg::MODE_CBRT)
                  || (r_mode == vcc_pkg::MODE_CROOT);
    assign is_root = is_unit || (r_mode == vcc_pkg::MODE_CCUBE);

    `VCC_ASSERT_NOW(a_root_no_sat, i_clk, i_rst_n, r_vld[ST_FIN] && is_root, !r_st[ST_FIN].of, "root curve raised saturation")
    `VCC_ASSERT_NOW(a_root_range, i_clk, i_rst_n, r_vld[ST_FIN] && is_unit, r_st[ST_FIN].ov <= 32'd65536, "root curve above one")
    `VCC_ASSERT_NOW(a_div_rem, i_clk, i_rst_n, r_vld[DIV_N], r_st[DIV_N].rem < span_eff, "divider remainder not below span")
    `VCC_ASSERT_NOW(a_pow_unit, i_clk, i_rst_n, r_vld[PR_LAST], r_st[PR_LAST].y <= 31'h4000_0000, "exp2 product above one")
    `VCC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !pipe_en, $stable(r_vld), "stage valids moved during stall")

endmodule

// ----- tb/vcc_tb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcc_tb_if
// Testbench-side note: the channel interfaces come from the RTL interface files;
// this file holds the beat record types used by the contrast curve testbench.
// ----------------------------------------------------------------------------
package vcc_tb_pkg;
    typedef struct packed {
        logic [31:0] curve_value;
        logic        saturated;
        logic        last_out;
    } t_curve_beat;
endpackage

// ----- tb/tb_value_contrast_curve_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_value_contrast_curve_top
// Drives samples through every transfer curve under several range settings,
// predicts each mapped value in fixed point and compares every result beat,
// with random idling on both channels and a long receiver stall.
// ----------------------------------------------------------------------------
module tb_value_contrast_curve_top;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    vcc_in_if  smp_if();
    vcc_out_if crv_if();
    vcc_cfg_if cfg_if();

    value_contrast_curve_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_sample(smp_if.sink), .o_curve(crv_if.source), .i_cfg(cfg_if.sink)
    );

    logic signed [63:0]       cur_min;
    logic [63:0]              cur_span;
    logic [2:0]               cur_mode;
    vcc_tb_pkg::t_curve_beat  expected_q[$];
    int                       errors = 0;
    int                       n_samples = 0;
    int                       n_results = 0;
    bit                       idle_en = 1'b1;
    int                       hold_off = 0;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v_in);
        logic [63:0] v, res, b;
        v = v_in; res = 0; b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // x^(num/den) in Q16.16 via log2 by squaring and exp2 by root products
    function automatic logic [63:0] frac_power(input logic [63:0] x_in,
                                               input logic [63:0] num,
                                               input logic [63:0] den);
        logic [63:0] x, m, fb, nl, nt, k, r, y, h;
        int e;
        x = x_in; fb = 0; e = 0;
        if (x == 0) return 0;
        if (x > 65536) x = 65536;
        for (int i = 0; i <= 16; i++) if (x[i]) e = i;
        m = x << (30 - e);
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            fb = fb << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                fb = fb | 1;
            end
        end
        nl = ((64'(16 - e)) << 24) - fb;
        nt = nl * num / den;
        k = nt >> 24;
        r = nt & ((64'd1 << 24) - 1);
        y = 64'd1 << 30;
        h = 64'd1 << 29;
        for (int i = 1; i <= 24; i++) begin
            h = floor_sqrt(h << 30);
            if (r[24 - i]) y = (y * h) >> 30;
        end
        y = (k >= 31) ? 64'd0 : (y >> k);
        return (y + 8192) >> 14;
    endfunction

    function automatic vcc_tb_pkg::t_curve_beat map_sample(input logic [31:0] raw,
                                                           input logic lst);
        logic signed [63:0] s, f, c, d, v, q;
        logic [63:0] span, mag, dm;
        vcc_tb_pkg::t_curve_beat res;
        logic flag;
        flag = 1'b0;
        s = {{32{raw[31]}}, raw};
        span = (cur_span == 0) ? 64'd1 : cur_span;
        f = ((s - cur_min) * 64'sd65536) / $signed(span);
        mag = (f < 0) ? -f : f;
        c = (f < 0) ? 64'sd0 : ((f > 65536) ? 64'sd65536 : f);
        d = c - 32768;
        dm = (d < 0) ? -d : d;
        v = 0;
        case (cur_mode)
            vcc_pkg::MODE_LINEAR: v = f;
            vcc_pkg::MODE_SQUARE: begin
                if (mag > (64'd1 << 24)) begin flag = 1; v = 64'sh7FFFFFFF; end
                else v = (mag * mag) >> 16;
            end
            vcc_pkg::MODE_CUBE: begin
                if (mag > (64'd1 << 21)) begin
                    flag = 1;
                    v = (f < 0) ? -64'sh80000000 : 64'sh7FFFFFFF;
                end else begin
                    q = (mag * mag * mag) >> 32;
                    v = (f < 0) ? -q : q;
                end
            end
            vcc_pkg::MODE_SQRT:  v = floor_sqrt(c << 16);
            vcc_pkg::MODE_CBRT:  v = frac_power(c, 3333, 10000);
            vcc_pkg::MODE_CCUBE: begin
                q = (dm * dm * dm) >> 30;
                v = 32768 + ((d < 0) ? -q : q);
            end
            vcc_pkg::MODE_CROOT: begin
                q = (5 * frac_power(dm, 33, 100) + 4) >> 3;
                v = 32768 + ((d < 0) ? -q : q);
            end
            default: v = s;
        endcase
        if (cur_mode <= vcc_pkg::MODE_CUBE) begin
            if (v > 64'sh7FFFFFFF) begin flag = 1; v = 64'sh7FFFFFFF; end
            if (v < -64'sh80000000) begin flag = 1; v = -64'sh80000000; end
        end
        res.curve_value = v[31:0];
        res.saturated = flag;
        res.last_out = lst;
        return res;
    endfunction

    function automatic bit take_idle();
        return idle_en && ($urandom_range(99) < 27);
    endfunction

    initial begin
        smp_if.valid = 0; smp_if.sample_value = 0; smp_if.last_in = 0;
        crv_if.ready = 0;
        cfg_if.valid = 0; cfg_if.index = vcc_pkg::CFG_RANGE_MIN; cfg_if.data = 0;
    end

    // result side: random ready, long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            crv_if.ready <= 1'b0;
        end else begin
            crv_if.ready <= i_rst_n && !take_idle();
        end
    end

    always @(posedge i_clk) begin
        vcc_tb_pkg::t_curve_beat got, want;
        if (i_rst_n && crv_if.valid && crv_if.ready) begin
            got.curve_value = crv_if.curve_value;
            got.saturated = crv_if.saturated;
            got.last_out = crv_if.last_out;
            n_results++;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: value %h", got.curve_value);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.curve_value !== want.curve_value) begin
                    $error("curve_value expected %h actual %h", want.curve_value,
                           got.curve_value);
                    errors++;
                end
                if (got.saturated !== want.saturated) begin
                    $error("saturated expected %0b actual %0b", want.saturated,
                           got.saturated);
                    errors++;
                end
                if (got.last_out !== want.last_out) begin
                    $error("last_out expected %0b actual %0b", want.last_out,
                           got.last_out);
                    errors++;
                end
            end
        end
    end

    // valid stays high after the beat so that the next one can follow directly
    task automatic send_sample(input logic [31:0] val, input logic lst);
        while (take_idle()) begin
            smp_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.sample_value <= val;
        smp_if.last_in <= lst;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        expected_q.push_back(map_sample(val, lst));
        n_samples++;
        @(negedge i_clk);
    endtask

    task automatic stop_samples();
        smp_if.valid <= 1'b0;
    endtask

    task automatic drain();
        stop_samples();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (110) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [vcc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            vcc_pkg::CFG_RANGE_MIN:  cur_min = {{32{val[31]}}, val};
            vcc_pkg::CFG_RANGE_SPAN: cur_span = {33'd0, val[30:0]};
            vcc_pkg::CFG_CURVE_MODE: cur_mode = val[2:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_range(input logic [31:0] mn, input logic [31:0] sp,
                             input logic [2:0] md);
        write_reg(vcc_pkg::CFG_RANGE_MIN, mn);
        write_reg(vcc_pkg::CFG_RANGE_SPAN, sp);
        write_reg(vcc_pkg::CFG_CURVE_MODE, {29'd0, md});
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(3))
            0: return $urandom();
            1: return cur_min[31:0] + ($urandom_range(70000) - 2000);
            2: return cur_min[31:0] + $urandom_range(cur_span[31:0] + 4000);
            default: return {{14{1'($urandom_range(1))}}, 18'($urandom())};
        endcase
    endfunction

    task automatic test_directed_edges();
        logic [31:0] edge_vals[8];
        edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                      32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0002_0000};
        for (int md = 0; md < 8; md++) begin
            set_range(32'h0, 32'h0001_0000, md[2:0]);
            for (int i = 0; i < 3; i++)
                send_sample(edge_vals[$urandom_range(7)], i == 2);
            drain();
        end
        // zero span, extreme minimum
        set_range(32'h8000_0000, 32'h0, vcc_pkg::MODE_LINEAR);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        drain();
        set_range(32'h7FFF_FFFF, 32'h7FFF_FFFF, vcc_pkg::MODE_CUBE);
        send_sample(32'h8000_0000, 1'b1);
        drain();
    endtask

    task automatic test_random_curves();
        logic [31:0] spans[4];
        spans = '{32'h1, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_0400};
        for (int ph = 0; ph < 8; ph++) begin
            set_range($urandom() >> $urandom_range(31), spans[ph % 4] +
                      ((ph > 3) ? $urandom_range(50000) : 0), 3'($urandom_range(7)));
            idle_en = (ph != 5);
            for (int i = 0; i < 50; i++)
                send_sample(rand_sample(), 1'($urandom_range(1)));
            drain();
        end
        idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        set_range(32'hFFFF_0000, 32'h0002_0000, vcc_pkg::MODE_CROOT);
        fork
            hold_off = 400;
            for (int i = 0; i < 150; i++) send_sample(rand_sample(), i[0]);
        join
        // sender waits for every result before the next run
        stop_samples();
        while (expected_q.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
        set_range(32'h0, 32'h0001_0000, vcc_pkg::MODE_CBRT);
        for (int i = 0; i < 50; i++) send_sample(rand_sample(), 1'($urandom_range(1)));
        drain();
    endtask

    initial begin
        cur_min = 0; cur_span = 65536; cur_mode = vcc_pkg::MODE_LINEAR;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_edges();
        test_random_curves();
        test_backpressure();
        $display("Ran %0d samples (%0d results) over all eight curve codes,", n_samples,
                 n_results);
        $display("extreme ranges, zero span, random idling and a long output stall.");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
